### hw/rtl/yuyv_pkg.sv
// ----------------------------------------------------------------------------
// yuyv_pkg
// Shared types, widths and constants for the YUYV to RGB888 converter.
// ----------------------------------------------------------------------------
package yuyv_pkg;

    // Sample and coefficient widths
    localparam int unsigned SampleW  = 8;
    localparam int unsigned CoefW    = 18;
    localparam int unsigned FracW    = 16;
    localparam int unsigned DiffW    = SampleW + 1;
    // Signed product of an unsigned coefficient and a signed chroma difference
    localparam int unsigned ProdW    = CoefW + 1 + DiffW;
    // Channel accumulator: luma scaled plus or minus up to two products
    localparam int unsigned AccW     = ProdW + 1;

    // Stream payload widths
    localparam int unsigned InDataW  = 4 * SampleW;
    localparam int unsigned OutDataW = 6 * SampleW;

    // Configuration port
    localparam int unsigned ApbAddrW = 4;
    localparam int unsigned ApbDataW = 32;

    // Register map, by index (byte address is four times the index)
    typedef enum logic [1:0] {
        REG_COEF_RED_FROM_V   = 2'd0,
        REG_COEF_GREEN_FROM_V = 2'd1,
        REG_COEF_GREEN_FROM_U = 2'd2,
        REG_COEF_BLUE_FROM_U  = 2'd3
    } t_reg_idx;

    // Reset gains in unsigned Q2.16
    localparam logic [CoefW-1:0] CoefRedFromVRst   = 18'd89831;
    localparam logic [CoefW-1:0] CoefGreenFromVRst = 18'd45744;
    localparam logic [CoefW-1:0] CoefGreenFromURst = 18'd22127;
    localparam logic [CoefW-1:0] CoefBlueFromURst  = 18'd113538;

    localparam logic [SampleW-1:0] ChromaOffset = 8'd128;
    localparam logic [SampleW-1:0] ChanMax      = 8'd255;

    typedef logic        [SampleW-1:0] t_sample;
    typedef logic        [CoefW-1:0]   t_coef;
    typedef logic signed [DiffW-1:0]   t_diff;
    typedef logic signed [ProdW-1:0]   t_prod;
    typedef logic signed [AccW-1:0]    t_acc;

    // Remove the chroma offset, giving a signed difference
    function automatic t_diff chroma_diff(input t_sample c);
        chroma_diff = $signed({1'b0, c}) - $signed({1'b0, ChromaOffset});
    endfunction

    // Luma moved to the Q.16 grid of the accumulator
    function automatic t_acc luma_scaled(input t_sample y);
        luma_scaled = $signed({{(AccW - SampleW - FracW){1'b0}}, y, {FracW{1'b0}}});
    endfunction

    // Widen a product to accumulator width with sign extension
    function automatic t_acc prod_ext(input t_prod p);
        prod_ext = $signed({p[ProdW-1], p});
    endfunction

    // Floor by dropping the fraction bits, then saturate to 0..255
    function automatic t_sample chan_clamp(input t_acc acc);
        if (acc[AccW-1]) begin
            chan_clamp = '0;
        end else if (|acc[AccW-2:FracW+SampleW]) begin
            chan_clamp = ChanMax;
        end else begin
            chan_clamp = acc[FracW+SampleW-1:FracW];
        end
    endfunction

endpackage

### hw/rtl/yuyv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_core
// Converts one packed YUYV word into two RGB888 pixels per request.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the s_axis channel; tdata carries one YUYV word. The
// two converted pixels leave on the m_axis channel as one 48-bit request.
// The four colour gains are unsigned Q2.16 registers on the APB port at byte
// addresses 0, 4, 8 and 12; they should only be written while no request is
// in flight. Reads return the current gain; pready is always high.
// The datapath is a four-stage pipeline: input register, four 18x9 chroma
// multiplications, channel sums, then floor and saturation into the output
// register. An accepted request moves through the stage registers in turn
// and is offered on m_axis from the output register; one request per cycle
// is taken for as long as the receiver keeps tready high. When the receiver
// stalls, the output stage holds its request and earlier stages keep
// filling until each holds one request; nothing is dropped or duplicated.
// Reset empties the pipeline and returns the gains to their default values.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [yuyv_pkg::ApbAddrW-1:0] paddr,
    input  logic [yuyv_pkg::ApbDataW-1:0] pwdata,
    output logic [yuyv_pkg::ApbDataW-1:0] prdata,
    output logic                        pready,
    // Input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: luma_first, chroma_u, luma_second, chroma_v (8 bits each, low first)
    input  logic [yuyv_pkg::InDataW-1:0]  s_axis_tdata,
    // Output stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata: red_first, green_first, blue_first, red_second, green_second,
    // blue_second (8 bits each, low first)
    output logic [yuyv_pkg::OutDataW-1:0] m_axis_tdata
);
    import yuyv_pkg::*;

    // Gain registers
    t_coef r_coef_rv, r_coef_gv, r_coef_gu, r_coef_bu;

    // Stage 1: captured samples
    logic    r_v1;
    t_sample r_y1_s1, r_y2_s1;
    t_diff   r_du_s1, r_dv_s1;

    // Stage 2: products
    logic    r_v2;
    t_sample r_y1_s2, r_y2_s2;
    t_prod   r_p_rv, r_p_gv, r_p_gu, r_p_bu;

    // Stage 3: channel sums
    logic    r_v3;
    t_acc    r_r1, r_g1, r_b1, r_r2, r_g2, r_b2;

    // Stage 4: output register
    logic                r_v4;
    logic [OutDataW-1:0] r_out;

    logic ld1, ld2, ld3, ld4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic cfg_wr;
    t_reg_idx cfg_idx;
    t_acc y1_acc, y2_acc;

    // Configuration port decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ApbAddrW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_rv <= CoefRedFromVRst;
            r_coef_gv <= CoefGreenFromVRst;
            r_coef_gu <= CoefGreenFromURst;
            r_coef_bu <= CoefBlueFromURst;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_COEF_RED_FROM_V:   r_coef_rv <= pwdata[CoefW-1:0];
                REG_COEF_GREEN_FROM_V: r_coef_gv <= pwdata[CoefW-1:0];
                REG_COEF_GREEN_FROM_U: r_coef_gu <= pwdata[CoefW-1:0];
                REG_COEF_BLUE_FROM_U:  r_coef_bu <= pwdata[CoefW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data selection
    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_COEF_RED_FROM_V:   prdata = {{(ApbDataW-CoefW){1'b0}}, r_coef_rv};
            REG_COEF_GREEN_FROM_V: prdata = {{(ApbDataW-CoefW){1'b0}}, r_coef_gv};
            REG_COEF_GREEN_FROM_U: prdata = {{(ApbDataW-CoefW){1'b0}}, r_coef_gu};
            REG_COEF_BLUE_FROM_U:  prdata = {{(ApbDataW-CoefW){1'b0}}, r_coef_bu};
            default:               prdata = '0;
        endcase
    end

    // Each stage may load when it is empty or its request moves on
    assign rdy4 = !r_v4 || m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign s_axis_tready = rdy1;
    assign ld1 = rdy1;
    assign ld2 = rdy2;
    assign ld3 = rdy3;
    assign ld4 = rdy4;

    // Valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= s_axis_tvalid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
        end
    end

    // Stage 1: unpack the word and remove the chroma offset
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_y1_s1 <= s_axis_tdata[SampleW-1:0];
            r_du_s1 <= chroma_diff(s_axis_tdata[2*SampleW-1:SampleW]);
            r_y2_s1 <= s_axis_tdata[3*SampleW-1:2*SampleW];
            r_dv_s1 <= chroma_diff(s_axis_tdata[4*SampleW-1:3*SampleW]);
        end
    end

    // Stage 2: the four chroma products, shared by both pixels
    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_y1_s2 <= r_y1_s1;
            r_y2_s2 <= r_y2_s1;
            r_p_rv  <= $signed({1'b0, r_coef_rv}) * r_dv_s1;
            r_p_gv  <= $signed({1'b0, r_coef_gv}) * r_dv_s1;
            r_p_gu  <= $signed({1'b0, r_coef_gu}) * r_du_s1;
            r_p_bu  <= $signed({1'b0, r_coef_bu}) * r_du_s1;
        end
    end

    // Stage 3: add the scaled luma to the products for each channel
    assign y1_acc = luma_scaled(r_y1_s2);
    assign y2_acc = luma_scaled(r_y2_s2);

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r_r1 <= y1_acc + prod_ext(r_p_rv);
            r_g1 <= y1_acc - prod_ext(r_p_gv) - prod_ext(r_p_gu);
            r_b1 <= y1_acc + prod_ext(r_p_bu);
            r_r2 <= y2_acc + prod_ext(r_p_rv);
            r_g2 <= y2_acc - prod_ext(r_p_gv) - prod_ext(r_p_gu);
            r_b2 <= y2_acc + prod_ext(r_p_bu);
        end
    end

    // Stage 4: floor, saturate and pack into the output register
    always_ff @(posedge i_clk) begin
        if (ld4) begin
            r_out <= {chan_clamp(r_b2), chan_clamp(r_g2), chan_clamp(r_r2),
                      chan_clamp(r_b1), chan_clamp(r_g1), chan_clamp(r_r1)};
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = r_out;

endmodule
